/* hdl/ipdd_pkg.sv */
package ipdd_pkg;

  localparam int NIB_W      = 4;
  localparam int LANES      = 2;
  localparam int PAIR_W     = LANES * NIB_W;
  localparam int PROD_W     = 2 * NIB_W;
  localparam int PSUM_W     = PROD_W + 1;
  localparam int SUM_W      = 21;
  localparam int SCALE_W    = 32;
  localparam int SPROD_W    = 2 * SCALE_W;
  localparam int PART_W     = SUM_W + SCALE_W;
  localparam int FULL_W     = SUM_W + SPROD_W;
  localparam int FRAC_SHIFT = 16;
  localparam int VAL_W      = 64;
  localparam int IN_DATA_W  = 2 * PAIR_W + 2 * SCALE_W;
  localparam int OUT_RAW_W  = SUM_W + VAL_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [VAL_W-1:0] val_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // half an output LSB at 32 fractional bits
  localparam logic [FULL_W-1:0] ROUND_HALF = FULL_W'(1) << (FRAC_SHIFT - 1);

  typedef struct packed {
    sum_t               sum;
    logic [SCALE_W-1:0] row_scale;
    logic [SCALE_W-1:0] col_scale;
  } dq_req_t;

  typedef struct packed {
    sum_t sum;
    val_t scaled;
    logic sat;
  } dq_res_t;

endpackage

/* hdl/int4_packed_dot_product_dequant.sv */
// Signed int4 packed dot product with Q16.16 dequantization.
// Input channel (in_*): one item per byte pair; in_tdata carries the activation
// byte, the weight byte and the row/column scales, in_tlast ends a dot product.
// Each byte holds two signed nibbles; two product lanes handle them and a
// merge stage adds both products into a saturating 21-bit running sum.
// Output channel (out_*): one item per dot product, issued for the item with
// in_tlast set: raw sum, sum * row_scale * col_scale rounded to Q47.16 and
// saturated to 64 bits, and a saturation flag in out_tuser.
// Throughput: one item per cycle while in_tready is high. The result passes
// through the request register, the scale multiply, two 21x32 partial
// products, merge and round, and saturation into the output register.
// The dequant pipeline holds up to five results; when the receiver stalls
// the stages fill up and in_tready drops, for every item, only once all five
// stages are full and out_tready is low.
// Reset (synchronous, active low) clears the running sum and all valid bits.
module int4_packed_dot_product_dequant (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // act_pair[7:0], wgt_pair[15:8], row_scale[47:16], col_scale[79:48]
  input  logic [ipdd_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // dot_sum[20:0], scaled_value[84:21], zero pad [87:85]
  output logic [ipdd_pkg::OUT_DATA_W-1:0]   out_tdata,
  // saturated[0]
  output logic                              out_tuser
);

  localparam int SW = ipdd_pkg::SUM_W;
  localparam int PW = ipdd_pkg::PAIR_W;
  localparam int CW = ipdd_pkg::SCALE_W;

  logic [PW-1:0] act_pair;
  logic [PW-1:0] wgt_pair;
  logic signed [ipdd_pkg::PROD_W-1:0] lane_prod [ipdd_pkg::LANES];
  logic signed [ipdd_pkg::PSUM_W-1:0] pair_sum;
  logic signed [SW:0]                 acc_wide;
  ipdd_pkg::sum_t running_sum_r;
  ipdd_pkg::sum_t running_sum_nxt;
  ipdd_pkg::sum_t acc;
  logic in_acc;

  ipdd_pkg::dq_req_t req;
  ipdd_pkg::dq_res_t res;
  logic req_ready;

  assign act_pair = in_tdata[PW-1:0];
  assign wgt_pair = in_tdata[2*PW-1:PW];

  for (genvar i = 0; i < ipdd_pkg::LANES; i++) begin : g_lane
    ipdd_lane u_lane (
      .act_nib (act_pair[i*ipdd_pkg::NIB_W +: ipdd_pkg::NIB_W]),
      .wgt_nib (wgt_pair[i*ipdd_pkg::NIB_W +: ipdd_pkg::NIB_W]),
      .prod    (lane_prod[i])
    );
  end

  assign pair_sum = ipdd_pkg::PSUM_W'(lane_prod[0]) + ipdd_pkg::PSUM_W'(lane_prod[1]);
  assign acc_wide = (SW+1)'(running_sum_r) + (SW+1)'(pair_sum);

  always_comb begin
    if (acc_wide[SW] != acc_wide[SW-1]) begin
      acc = acc_wide[SW] ? ipdd_pkg::SUM_MIN : ipdd_pkg::SUM_MAX;
    end else begin
      acc = acc_wide[SW-1:0];
    end
  end

  assign in_tready = req_ready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    running_sum_nxt = running_sum_r;
    if (in_acc) begin
      running_sum_nxt = in_tlast ? '0 : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
    end else begin
      running_sum_r <= running_sum_nxt;
    end
  end

  assign req.sum       = acc;
  assign req.row_scale = in_tdata[2*PW +: CW];
  assign req.col_scale = in_tdata[2*PW+CW +: CW];

  ipdd_dequant u_dequant (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_acc && in_tlast),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {(ipdd_pkg::OUT_DATA_W-ipdd_pkg::OUT_RAW_W)'(0), res.scaled, res.sum};
  assign out_tuser = res.sat;

endmodule

/* hdl/ipdd_lane.sv */
module ipdd_lane (
  input  logic [ipdd_pkg::NIB_W-1:0]         act_nib,
  input  logic [ipdd_pkg::NIB_W-1:0]         wgt_nib,
  output logic signed [ipdd_pkg::PROD_W-1:0] prod
);

  logic signed [ipdd_pkg::PROD_W-1:0] act_ext;
  logic signed [ipdd_pkg::PROD_W-1:0] wgt_ext;

  assign act_ext = {{(ipdd_pkg::PROD_W-ipdd_pkg::NIB_W){act_nib[ipdd_pkg::NIB_W-1]}}, act_nib};
  assign wgt_ext = {{(ipdd_pkg::PROD_W-ipdd_pkg::NIB_W){wgt_nib[ipdd_pkg::NIB_W-1]}}, wgt_nib};

  // -8 * -8 = 64 still fits in 8 signed bits
  assign prod = act_ext * wgt_ext;

endmodule

/* hdl/ipdd_dequant.sv */
module ipdd_dequant (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  ipdd_pkg::dq_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output ipdd_pkg::dq_res_t res
);

  localparam int SW = ipdd_pkg::SUM_W;
  localparam int CW = ipdd_pkg::SCALE_W;

  // stage 1: request
  logic              v1_r;
  ipdd_pkg::dq_req_t s1_r;
  // stage 2: scale product, magnitude
  logic                          v2_r;
  logic [ipdd_pkg::SPROD_W-1:0]  p2_r;
  logic [SW-1:0]                 mag2_r;
  logic                          neg2_r;
  ipdd_pkg::sum_t                sum2_r;
  // stage 3: two partial products
  logic                          v3_r;
  logic [ipdd_pkg::PART_W-1:0]   pa3_r;
  logic [ipdd_pkg::PART_W-1:0]   pb3_r;
  logic                          neg3_r;
  ipdd_pkg::sum_t                sum3_r;
  // stage 4: merged and rounded
  logic                          v4_r;
  logic [ipdd_pkg::FULL_W-1:0]   t4_r;
  logic                          neg4_r;
  ipdd_pkg::sum_t                sum4_r;
  // stage 5: output register
  logic                          v5_r;
  ipdd_pkg::dq_res_t             res_r;
  ipdd_pkg::dq_res_t             res_nxt;

  logic go1, go2, go3, go4, go5;
  logic [SW-1:0] mag_nxt;
  logic [ipdd_pkg::VAL_W-1:0] q4;
  logic over4;

  // each stage moves when it is empty or its successor moves
  assign go5 = !v5_r || res_ready;
  assign go4 = !v4_r || go5;
  assign go3 = !v3_r || go4;
  assign go2 = !v2_r || go3;
  assign go1 = !v1_r || go2;
  assign req_ready = go1;

  assign mag_nxt = s1_r.sum[SW-1] ? SW'(-s1_r.sum) : SW'(s1_r.sum);

  assign over4 = |t4_r[ipdd_pkg::FULL_W-1:ipdd_pkg::FRAC_SHIFT+ipdd_pkg::VAL_W];
  assign q4    = t4_r[ipdd_pkg::FRAC_SHIFT+ipdd_pkg::VAL_W-1:ipdd_pkg::FRAC_SHIFT];

  always_comb begin
    res_nxt.sum    = sum4_r;
    res_nxt.sat    = 1'b0;
    res_nxt.scaled = ipdd_pkg::val_t'(q4);
    if (over4) begin
      res_nxt.sat    = 1'b1;
      res_nxt.scaled = neg4_r ? ipdd_pkg::VAL_MIN : ipdd_pkg::VAL_MAX;
    end else if (neg4_r) begin
      if (q4 > ipdd_pkg::VAL_W'(ipdd_pkg::VAL_MIN)) begin
        res_nxt.sat    = 1'b1;
        res_nxt.scaled = ipdd_pkg::VAL_MIN;
      end else begin
        res_nxt.scaled = ipdd_pkg::val_t'(-q4);
      end
    end else if (q4[ipdd_pkg::VAL_W-1]) begin
      res_nxt.sat    = 1'b1;
      res_nxt.scaled = ipdd_pkg::VAL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (go1) v1_r <= req_valid;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
      if (go4) v4_r <= v3_r;
      if (go5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go1 && req_valid) begin
      s1_r <= req;
    end
    if (go2 && v1_r) begin
      p2_r   <= ipdd_pkg::SPROD_W'(s1_r.row_scale) * ipdd_pkg::SPROD_W'(s1_r.col_scale);
      mag2_r <= mag_nxt;
      neg2_r <= s1_r.sum[SW-1];
      sum2_r <= s1_r.sum;
    end
    if (go3 && v2_r) begin
      pa3_r  <= ipdd_pkg::PART_W'(mag2_r) * ipdd_pkg::PART_W'(p2_r[CW-1:0]);
      pb3_r  <= ipdd_pkg::PART_W'(mag2_r) * ipdd_pkg::PART_W'(p2_r[2*CW-1:CW]);
      neg3_r <= neg2_r;
      sum3_r <= sum2_r;
    end
    if (go4 && v3_r) begin
      t4_r   <= {pb3_r, CW'(0)} + ipdd_pkg::FULL_W'(pa3_r) + ipdd_pkg::ROUND_HALF;
      neg4_r <= neg3_r;
      sum4_r <= sum3_r;
    end
    if (go5 && v4_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = v5_r;
  assign res       = res_r;

endmodule

/* dv/int4_packed_dot_product_dequant_test.sv */
`timescale 1ns / 100ps

module int4_packed_dot_product_dequant_test;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          TAIL_CYCLES    = 60;
  localparam int          RANDOM_ITEMS   = 400;
  localparam logic [31:0] ONE_Q16        = 32'h0001_0000;
  localparam logic [31:0] SCALE_MAX      = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_e;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ipdd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ipdd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  ipdd_pkg::sum_t    acc_sum = '0;
  ipdd_pkg::dq_res_t dot_results_q[$];
  int                n_mismatch = 0;
  int                idle_cycles = 0;
  pace_e             in_pace = PACE_LIGHT;
  pace_e             out_pace = PACE_LIGHT;

  int4_packed_dot_product_dequant i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int nibble_val(logic [3:0] n);
    return n[3] ? int'(n) - 16 : int'(n);
  endfunction

  function automatic int pair_dot(logic [7:0] act, logic [7:0] wgt);
    return nibble_val(act[3:0]) * nibble_val(wgt[3:0]) +
           nibble_val(act[7:4]) * nibble_val(wgt[7:4]);
  endfunction

  // magnitude * rs * cs has 32 fraction bits; round half away from zero to 16
  function automatic ipdd_pkg::val_t dequantize(ipdd_pkg::sum_t s, logic [31:0] rs,
                                                logic [31:0] cs, output logic sat);
    logic        neg;
    logic [20:0] mag;
    logic [95:0] prod;
    logic [63:0] q;
    neg  = s[ipdd_pkg::SUM_W-1];
    mag  = neg ? -s : s;
    prod = 96'(mag) * 96'(rs) * 96'(cs) + 96'h8000;
    sat  = 1'b0;
    if (|prod[95:80]) begin
      sat = 1'b1;
      return neg ? ipdd_pkg::VAL_MIN : ipdd_pkg::VAL_MAX;
    end
    q = prod[79:16];
    if (neg) begin
      if (q > 64'h8000_0000_0000_0000) begin
        sat = 1'b1;
        return ipdd_pkg::VAL_MIN;
      end
      return -q;
    end
    if (q[63]) begin
      sat = 1'b1;
      return ipdd_pkg::VAL_MAX;
    end
    return q;
  endfunction

  function automatic void accumulate_pair(logic [7:0] act, logic [7:0] wgt,
                                          logic [31:0] rs, logic [31:0] cs,
                                          logic last);
    int                t;
    logic              sat;
    ipdd_pkg::dq_res_t r;
    t = int'(acc_sum) + pair_dot(act, wgt);
    if (t > int'(ipdd_pkg::SUM_MAX)) t = int'(ipdd_pkg::SUM_MAX);
    if (t < int'(ipdd_pkg::SUM_MIN)) t = int'(ipdd_pkg::SUM_MIN);
    acc_sum = ipdd_pkg::sum_t'(t);
    if (last) begin
      r.sum    = acc_sum;
      r.scaled = dequantize(acc_sum, rs, cs, sat);
      r.sat    = sat;
      dot_results_q.push_back(r);
      acc_sum = '0;
    end
  endfunction

  // ---------------------------------------------------------------- pacing

  function automatic int pick_gap(pace_e p);
    int r;
    r = $urandom_range(0, 99);
    case (p)
      PACE_FULL: return 0;
      PACE_LIGHT: begin
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        if (r < 99) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
      end
      default: begin
        if (r < 30) return 0;
        if (r < 70) return $urandom_range(1, 4);
        if (r < 90) return $urandom_range(5, 15);
        return $urandom_range(20, 40);
      end
    endcase
  endfunction

  function automatic pace_e pick_pace();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return PACE_FULL;
    if (r < 8) return PACE_LIGHT;
    return PACE_HEAVY;
  endfunction

  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = pick_gap(out_pace);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_pair(input logic [7:0] act, input logic [7:0] wgt,
                           input logic [31:0] rs, input logic [31:0] cs,
                           input logic last);
    int gap;
    gap = pick_gap(in_pace);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cs, rs, wgt, act};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    accumulate_pair(act, wgt, rs, cs, last);
  endtask

  // n items of the same pair, none of them closing the dot product
  task automatic send_repeat(input logic [7:0] act, input logic [7:0] wgt, input int n);
    repeat (n) send_pair(act, wgt, $urandom, $urandom, 1'b0);
  endtask

  // sender holds off until every pending result is out
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (dot_results_q.size() != 0);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string what, ipdd_pkg::dq_res_t want, ipdd_pkg::dq_res_t got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%t: %s: expected sum %0d value %0d sat %0b, got sum %0d value %0d sat %0b",
               $time, what, want.sum, want.scaled, want.sat, got.sum, got.scaled, got.sat);
  endtask

  always @(posedge clk) begin : result_check
    ipdd_pkg::dq_res_t want;
    ipdd_pkg::dq_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.sum    = out_tdata[ipdd_pkg::SUM_W-1:0];
      got.scaled = out_tdata[ipdd_pkg::SUM_W +: ipdd_pkg::VAL_W];
      got.sat    = out_tuser;
      if (dot_results_q.size() == 0) begin
        want = '0;
        note_mismatch("result with none pending", want, got);
      end else begin
        want = dot_results_q.pop_front();
        if (got.sum !== want.sum || got.scaled !== want.scaled || got.sat !== want.sat)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("int4_packed_dot_product_dequant_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_nibble_corners();
    send_pair(8'h88, 8'h88, ONE_Q16, ONE_Q16, 1'b1);
    send_pair(8'h77, 8'h88, ONE_Q16, ONE_Q16, 1'b1);
    send_pair(8'h77, 8'h77, ONE_Q16, ONE_Q16, 1'b1);
    send_pair(8'h00, 8'hFF, ONE_Q16, ONE_Q16, 1'b1);
    send_pair(8'h8F, 8'hF8, ONE_Q16, ONE_Q16, 1'b1);
    send_pair(8'h0F, 8'hF0, ONE_Q16, ONE_Q16, 1'b1);
    send_pair(8'hFF, 8'hFF, ONE_Q16, ONE_Q16, 1'b1);
    // three-item dot product, scales on earlier items are ignored
    send_pair(8'h78, 8'h87, SCALE_MAX, 32'h0, 1'b0);
    send_pair(8'h12, 8'hE3, 32'h0, SCALE_MAX, 1'b0);
    send_pair(8'hA5, 8'h5A, ONE_Q16, 32'h0002_8000, 1'b1);
    wait_results_done();
  endtask

  task automatic test_scale_corners();
    // exact half LSB rounds away from zero, just below it rounds to zero
    send_pair(8'h01, 8'h01, 32'h1, 32'h8000, 1'b1);
    send_pair(8'h0F, 8'h01, 32'h1, 32'h8000, 1'b1);
    send_pair(8'h01, 8'h01, 32'h1, 32'h7FFF, 1'b1);
    send_pair(8'h0F, 8'h01, 32'h1, 32'h7FFF, 1'b1);
    send_pair(8'h0F, 8'h01, 32'h1, 32'h8001, 1'b1);
    // zero scale, zero sum, then both scales at full range
    send_pair(8'h01, 8'h01, 32'h0, SCALE_MAX, 1'b1);
    send_pair(8'h88, 8'h88, SCALE_MAX, 32'h0, 1'b1);
    send_pair(8'h00, 8'h00, SCALE_MAX, SCALE_MAX, 1'b1);
    send_pair(8'h88, 8'h88, SCALE_MAX, SCALE_MAX, 1'b1);
    send_pair(8'h77, 8'h88, SCALE_MAX, SCALE_MAX, 1'b1);
    wait_results_done();
  endtask

  // with both scales at full range the value is about sum * 2^48:
  // |sum| = 2^15 + 1 clips on the value, 2^16 + 1 already overflows the wide product
  task automatic test_value_limits();
    in_pace = PACE_FULL;
    send_repeat(8'h88, 8'h88, 256);
    send_pair(8'h01, 8'h01, SCALE_MAX, SCALE_MAX, 1'b1);
    send_repeat(8'h77, 8'h88, 292);
    send_repeat(8'h18, 8'h87, 1);
    send_pair(8'h01, 8'h0F, SCALE_MAX, SCALE_MAX, 1'b1);
    send_repeat(8'h88, 8'h88, 512);
    send_pair(8'h01, 8'h01, SCALE_MAX, SCALE_MAX, 1'b1);
    in_pace = PACE_LIGHT;
    wait_results_done();
  endtask

  // full-rate single-item rows against a slow receiver to fill the pipeline
  task automatic test_backpressure();
    in_pace  = PACE_FULL;
    out_pace = PACE_HEAVY;
    repeat (40) send_pair(8'($urandom), 8'($urandom), $urandom, $urandom, 1'b1);
    out_pace = PACE_LIGHT;
    in_pace  = PACE_LIGHT;
    wait_results_done();
  endtask

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 8'($urandom);
    case ($urandom_range(0, 3))
      0:       return 8'h88;
      1:       return 8'h77;
      2:       return 8'h78;
      default: return 8'h87;
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return SCALE_MAX - $urandom_range(0, 255);
    if (r < 6)  return $urandom_range(0, 32'h0003_FFFF);
    return $urandom;
  endfunction

  function automatic int rand_row_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 16);
    if (r < 97) return $urandom_range(17, 64);
    return $urandom_range(200, 600);
  endfunction

  task automatic test_random_rows();
    int sent;
    int len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        in_pace  = pick_pace();
        out_pace = pick_pace();
      end
      len = rand_row_len();
      for (int k = 0; k < len; k++)
        send_pair(rand_byte(), rand_byte(), rand_scale(), rand_scale(), k == len - 1);
      sent += len;
      if ($urandom_range(0, 19) == 0) wait_results_done();
    end
    in_pace  = PACE_LIGHT;
    out_pace = PACE_LIGHT;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_nibble_corners();
    test_scale_corners();
    test_value_limits();
    test_backpressure();
    test_random_rows();
    out_pace = PACE_FULL;
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && dot_results_q.size() == 0) begin
      $display("int4_packed_dot_product_dequant_test: done, clean");
    end else begin
      $display("int4_packed_dot_product_dequant_test: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ipdd_pkg.sv
hdl/ipdd_lane.sv
hdl/ipdd_dequant.sv
hdl/int4_packed_dot_product_dequant.sv
dv/int4_packed_dot_product_dequant_test.sv
